@@ rtl/pfau_pkg.sv @@
// Package: shared constants, command codes and state types for the prime field unit
`timescale 1ns / 1ps
`default_nettype none
package pfau_pkg;
   localparam int unsigned ModWidth  = 63;
   localparam int unsigned CmdWidth  = 3;
   localparam int unsigned CntWidth  = $clog2(ModWidth + 1);
   localparam logic [62:0] PrimeReset = 63'd9223372036854775783;
   localparam logic [ModWidth-1:0] SquareExp = ModWidth'(2);

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_POW = 3'd4,
      CMD_NEG = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDA,
      ST_REDB,
      ST_DISPATCH,
      ST_INV_DIV,
      ST_INV_MUL,
      ST_INV_UPD,
      ST_MUL,
      ST_POW_STEP,
      ST_POW_SQ,
      ST_DONE
   } state_type;

   // Return address after a shared multiply or inverse completes.
   typedef enum logic [2:0] {
      RET_RESULT,
      RET_POW_ACC,
      RET_POW_SQ,
      RET_INV_DIV,
      RET_INV_POW
   } ret_type;
endpackage
`default_nettype wire

@@ rtl/prime_field_arith_unit.sv @@
// Top level: bit-serial modular arithmetic unit over a configurable prime
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Dir  Handshake            Payload
// req_      in   req_tvalid/tready    tdata {operand_b, operand_a}, tuser command
// rsp_      out  rsp_tvalid/tready    tdata result
// csr_      in   csr_valid/csr_ready  csr_data prime (63 bits)
//
// One request at a time in the core. Each operand is reduced by a restoring remainder,
// one bit a cycle; a multiply shifts and adds until the multiplier bits run out. Add,
// subtract and negate finish in the dispatch state after both reductions. Power runs
// up to about 2*MOD_WIDTH multiplies; an inverse adds a divide and a multiply per
// Euclid step. A finished result waits in the output register, so the core takes
// the next request meanwhile and holds only when a second result is ready. Reset is
// synchronous: it idles the control, drops the result and loads the reset prime.
module prime_field_arith_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // [62:0] operand_a, [125:63] operand_b
   input  wire logic [2:0]    req_tuser,   // [2:0] command
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,   // [62:0] result
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [62:0]   csr_data
);
   localparam int unsigned W  = pfau_pkg::ModWidth;
   localparam int unsigned CW = pfau_pkg::CntWidth;

   logic [62:0]   prime_ff;
   logic [W-1:0]  m;
   assign m = prime_ff[W-1:0];

   pfau_pkg::state_type state_ff, state_in;
   pfau_pkg::ret_type   ret_ff, ret_in, iret_ff, iret_in;

   logic [pfau_pkg::CmdWidth-1:0] cmd_ff, cmd_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   // bit-serial divider: dividend shifts out, remainder builds up
   logic [W-1:0] dvd_ff, dvd_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // multiplier: acc += addend when mbit, addend doubles, multiplier shifts
   logic [W-1:0] macc_ff, macc_in, madd_ff, madd_in, mmul_ff, mmul_in;
   // Euclid registers
   logic [W-1:0] er_ff, er_in, enr_ff, enr_in, et_ff, et_in, ent_ff, ent_in;
   // power registers
   logic [W-1:0] pacc_ff, pacc_in, pbase_ff, pbase_in, pexp_ff, pexp_in;
   // core result, held until the output register is free
   logic [W-1:0] res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;

   // one restoring step: shift remainder and compare to divisor (W+1 bits)
   logic [W:0] rshift;
   logic       rfit;
   logic [W:0] rdiff;
   assign rshift = {rem_ff, dvd_ff[W-1]};
   assign rdiff  = rshift - {1'b0, dvs_ff};
   assign rfit   = !rdiff[W];

   // modular add of two values below m
   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] md);
      logic [W:0] s;
      logic [W:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, md};
      return d[W] ? s[W-1:0] : d[W-1:0];
   endfunction

   function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] md);
      return (y > x) ? (x - y + md) : (x - y);
   endfunction

   logic [W-1:0] madd_dbl, macc_add;
   assign madd_dbl = addm(madd_ff, madd_ff, m);
   assign macc_add = addm(macc_ff, madd_ff, m);

   assign req_tready = (state_ff == pfau_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(64 - W){1'b0}}, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= pfau_pkg::PrimeReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) prime_ff <= csr_data;
      end
      ret_ff <= ret_in;  iret_ff <= iret_in;  cmd_ff <= cmd_in;
      a_ff <= a_in;  b_ff <= b_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  dvs_ff <= dvs_in;  cnt_ff <= cnt_in;
      macc_ff <= macc_in;  madd_ff <= madd_in;  mmul_ff <= mmul_in;
      er_ff <= er_in;  enr_ff <= enr_in;  et_ff <= et_in;  ent_ff <= ent_in;
      pacc_ff <= pacc_in;  pbase_ff <= pbase_in;  pexp_ff <= pexp_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  iret_in = iret_ff;  cmd_in = cmd_ff;
      a_in = a_ff;  b_in = b_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  dvs_in = dvs_ff;  cnt_in = cnt_ff;
      macc_in = macc_ff;  madd_in = madd_ff;  mmul_in = mmul_ff;
      er_in = er_ff;  enr_in = enr_ff;  et_in = et_ff;  ent_in = ent_ff;
      pacc_in = pacc_ff;  pbase_in = pbase_ff;  pexp_in = pexp_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         pfau_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tuser;
               a_in   = req_tdata[W-1:0];
               b_in   = req_tdata[63 +: W];
               if (m < W'(2)) begin
                  res_in   = '0;
                  state_in = pfau_pkg::ST_DONE;
               end else begin
                  // reduce operand_a first
                  dvd_in   = req_tdata[W-1:0];
                  rem_in   = '0;
                  dvs_in   = m;
                  cnt_in   = CW'(W);
                  state_in = pfau_pkg::ST_REDA;
               end
            end
         end
         pfau_pkg::ST_REDA, pfau_pkg::ST_REDB, pfau_pkg::ST_INV_DIV: begin
            // advance one quotient bit; quotient collects into dvd low bit
            rem_in = rfit ? rdiff[W-1:0] : rshift[W-1:0];
            dvd_in = {dvd_ff[W-2:0], rfit};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               case (state_ff)
                  pfau_pkg::ST_REDA: begin
                     a_in   = rem_in;
                     dvd_in = b_ff;
                     rem_in = '0;
                     cnt_in = CW'(W);
                     state_in = pfau_pkg::ST_REDB;
                  end
                  pfau_pkg::ST_REDB: begin
                     b_in = rem_in;
                     state_in = pfau_pkg::ST_DISPATCH;
                  end
                  default: begin
                     // quotient q in dvd_in, remainder r - q*nr in rem_in;
                     // q reaches m only when nr is 1 and r is m
                     er_in  = enr_ff;
                     enr_in = rem_in;
                     macc_in = '0;
                     madd_in = ent_ff;
                     mmul_in = (dvd_in >= m) ? dvd_in - m : dvd_in;
                     ret_in  = pfau_pkg::RET_INV_DIV;
                     state_in = pfau_pkg::ST_MUL;
                  end
               endcase
            end
         end
         pfau_pkg::ST_DISPATCH: begin
            state_in = pfau_pkg::ST_DONE;
            case (cmd_ff)
               pfau_pkg::CMD_ADD: res_in = addm(a_ff, b_ff, m);
               pfau_pkg::CMD_SUB: res_in = subm(a_ff, b_ff, m);
               pfau_pkg::CMD_NEG: res_in = (a_ff == '0) ? '0 : m - a_ff;
               pfau_pkg::CMD_MUL: begin
                  macc_in = '0;  madd_in = a_ff;  mmul_in = b_ff;
                  ret_in = pfau_pkg::RET_RESULT;
                  state_in = pfau_pkg::ST_MUL;
               end
               pfau_pkg::CMD_DIV: begin
                  if (b_ff == '0) res_in = '0;
                  else begin
                     er_in = m;  enr_in = b_ff;  et_in = '0;  ent_in = W'(1);
                     iret_in = pfau_pkg::RET_INV_DIV;
                     state_in = pfau_pkg::ST_INV_UPD;
                  end
               end
               pfau_pkg::CMD_POW: begin
                  pacc_in = W'(1);
                  if (b_ff == pfau_pkg::SquareExp) begin
                     macc_in = '0;  madd_in = a_ff;  mmul_in = a_ff;
                     ret_in = pfau_pkg::RET_RESULT;
                     state_in = pfau_pkg::ST_MUL;
                  end else if (b_ff < (m >> 1)) begin
                     pbase_in = a_ff;  pexp_in = b_ff;
                     state_in = pfau_pkg::ST_POW_STEP;
                  end else begin
                     pexp_in = m - b_ff - W'(1);
                     er_in = m;  enr_in = a_ff;  et_in = '0;  ent_in = W'(1);
                     iret_in = pfau_pkg::RET_INV_POW;
                     state_in = pfau_pkg::ST_INV_UPD;
                  end
               end
               default: res_in = '0;
            endcase
         end
         pfau_pkg::ST_INV_UPD: begin
            // Euclid loop head: finished when nr is zero
            if (enr_ff == '0) begin
               if (iret_ff == pfau_pkg::RET_INV_DIV) begin
                  macc_in = '0;  madd_in = a_ff;  mmul_in = et_ff;
                  ret_in = pfau_pkg::RET_RESULT;
                  state_in = pfau_pkg::ST_MUL;
               end else begin
                  pbase_in = et_ff;
                  state_in = pfau_pkg::ST_POW_STEP;
               end
            end else begin
               dvd_in = er_ff;  rem_in = '0;  dvs_in = enr_ff;  cnt_in = CW'(W);
               state_in = pfau_pkg::ST_INV_DIV;
            end
         end
         pfau_pkg::ST_MUL: begin
            if (mmul_ff == '0) begin
               case (ret_ff)
                  pfau_pkg::RET_RESULT: begin
                     res_in = macc_ff;
                     state_in = pfau_pkg::ST_DONE;
                  end
                  pfau_pkg::RET_POW_ACC: begin
                     pacc_in = macc_ff;
                     state_in = pfau_pkg::ST_POW_SQ;
                  end
                  pfau_pkg::RET_POW_SQ: begin
                     pbase_in = macc_ff;
                     pexp_in  = pexp_ff >> 1;
                     state_in = pfau_pkg::ST_POW_STEP;
                  end
                  default: begin
                     et_in  = ent_ff;
                     ent_in = subm(et_ff, macc_ff, m);
                     state_in = pfau_pkg::ST_INV_UPD;
                  end
               endcase
            end else begin
               if (mmul_ff[0]) macc_in = macc_add;
               madd_in = madd_dbl;
               mmul_in = mmul_ff >> 1;
            end
         end
         pfau_pkg::ST_POW_STEP: begin
            if (pexp_ff == '0) begin
               res_in = pacc_ff;
               state_in = pfau_pkg::ST_DONE;
            end else if (pexp_ff[0]) begin
               macc_in = '0;  madd_in = pacc_ff;  mmul_in = pbase_ff;
               ret_in = pfau_pkg::RET_POW_ACC;
               state_in = pfau_pkg::ST_MUL;
            end else begin
               state_in = pfau_pkg::ST_POW_SQ;
            end
         end
         pfau_pkg::ST_POW_SQ: begin
            macc_in = '0;  madd_in = pbase_ff;  mmul_in = pbase_ff;
            ret_in = pfau_pkg::RET_POW_SQ;
            state_in = pfau_pkg::ST_MUL;
         end
         pfau_pkg::ST_DONE: begin
            // hold while the previous result still waits
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in = pfau_pkg::ST_IDLE;
            end
         end
         default: state_in = pfau_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench: checks the prime field unit against its own field arithmetic over several moduli
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam int unsigned IdleLimit = 100000;
   localparam logic [63:0] Mask63 = 64'h7fff_ffff_ffff_ffff;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [62:0]   csr_data = '0;

   logic [63:0]   field_prime = {1'b0, pfau_pkg::PrimeReset};
   logic [63:0]   pending_results[$];
   int unsigned   fail_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   hold_left = 0;
   bit            long_hold_req = 0;
   int unsigned   stall_mode = 0;
   int unsigned   mode_count = 0;

   always #2 clock = ~clock;

   prime_field_arith_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // ---- field arithmetic, all values below m < 2^63 ----
   function automatic logic [63:0] fadd(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (m - y > x) ? x + y : x + y - m;
   endfunction

   function automatic logic [63:0] fsub(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (y > x) ? x - y + m : x - y;
   endfunction

   function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] dbl;
      acc = 0;
      dbl = x;
      while (y != 0) begin
         if (y[0]) acc = fadd(acc, dbl, m);
         dbl = fadd(dbl, dbl, m);
         y = y >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] fpow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (e != 0) begin
         if (e[0]) acc = fmul(acc, base, m);
         base = fmul(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Euclid with coefficients kept reduced; zero maps to zero
   function automatic logic [63:0] finv(logic [63:0] x, logic [63:0] m);
      logic [63:0] r, nr, t, nt, q, next_t, next_r;
      r = m;
      nr = x;
      t = 0;
      nt = 1;
      while (nr != 0) begin
         q = r / nr;
         next_t = fsub(t, fmul(q % m, nt, m), m);
         next_r = r - q * nr;
         t = nt;
         nt = next_t;
         r = nr;
         nr = next_r;
      end
      return t;
   endfunction

   function automatic logic [63:0] field_result(logic [2:0] cmd, logic [62:0] op_a,
                                                logic [62:0] op_b);
      logic [63:0] m, a, b, res;
      m = field_prime & Mask63;
      if (m < 2) return 0;
      a = {1'b0, op_a} % m;
      b = {1'b0, op_b} % m;
      case (cmd)
         pfau_pkg::CMD_ADD: res = fadd(a, b, m);
         pfau_pkg::CMD_SUB: res = fsub(a, b, m);
         pfau_pkg::CMD_MUL: res = fmul(a, b, m);
         pfau_pkg::CMD_DIV: res = (b == 0) ? 64'd0 : fmul(a, finv(b, m), m);
         pfau_pkg::CMD_POW: begin
            if (b == {1'b0, pfau_pkg::SquareExp}) res = fmul(a, a, m);
            else if (b < (m >> 1)) res = fpow(a, b, m);
            else res = fpow(finv(a, m), m - b - 1, m);
         end
         pfau_pkg::CMD_NEG: res = (a == 0) ? 64'd0 : m - a;
         default: res = 0;
      endcase
      return res & Mask63;
   endfunction

   function automatic logic [62:0] rand_word();
      return 63'({$urandom, $urandom});
   endfunction

   // mostly reduced operands, sometimes a raw 63-bit word
   function automatic logic [62:0] rand_operand();
      logic [63:0] m;
      m = field_prime & Mask63;
      if ($urandom_range(0, 4) == 0 || m < 2) return rand_word();
      return 63'({1'b0, rand_word()} % m);
   endfunction

   function automatic logic [62:0] rand_exponent();
      logic [63:0] m;
      m = field_prime & Mask63;
      case ($urandom_range(0, 4))
         0: return 63'd2;
         1: return 63'($urandom_range(0, 40));
         2: return 63'(m - 1 - $urandom_range(0, 3));
         default: return rand_operand();
      endcase
   endfunction

   // ---- sender: one request, valid stays high into the next call ----
   task automatic send_request(logic [2:0] cmd, logic [62:0] op_a, logic [62:0] op_b);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, op_b, op_a};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(field_result(cmd, op_a, op_b));
   endtask

   task automatic idle_sender(int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random(int unsigned count);
      int unsigned burst;
      logic [2:0] cmd;
      while (count > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && count > 0) begin
            cmd = 3'($urandom_range(0, 7));
            if (cmd > pfau_pkg::CMD_NEG && $urandom_range(0, 3) != 0) cmd = pfau_pkg::CMD_MUL;
            send_request(cmd, rand_operand(),
                         (cmd == pfau_pkg::CMD_POW) ? rand_exponent() : rand_operand());
            burst--;
            count--;
         end
         idle_sender($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 40));
      end
   endtask

   // drain, let the core settle, then write the modulus
   task automatic write_prime(logic [62:0] value);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      field_prime = {1'b0, value};
   endtask

   // ---- receiver: check each result, stall in phases ----
   always @(posedge clock) begin
      logic [63:0] want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result %0d", rsp_tdata[62:0]);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[62:0] !== want[62:0]) begin
               $error("result: expected %0d, got %0d", want[62:0], rsp_tdata[62:0]);
               fail_count++;
            end
         end
      end
      if (long_hold_req && hold_left == 0) begin
         hold_left <= 400;
         long_hold_req <= 0;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else begin
         // change stall pattern whenever the low six bits of mode_count are zero: always ready, light or heavy stall
         mode_count <= mode_count + 1;
         if (mode_count[5:0] == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog: any handshake resets the idle count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---- tests ----
   task automatic test_reset_prime();
      logic [62:0] top;
      top = pfau_pkg::PrimeReset - 1;
      send_request(pfau_pkg::CMD_ADD, top, top);
      send_request(pfau_pkg::CMD_ADD, 63'd0, 63'd0);
      send_request(pfau_pkg::CMD_SUB, 63'd0, top);
      send_request(pfau_pkg::CMD_SUB, top, 63'd5);
      send_request(pfau_pkg::CMD_MUL, top, top);
      send_request(pfau_pkg::CMD_MUL, 63'd0, top);
      send_request(pfau_pkg::CMD_DIV, 63'd12345, 63'd0);
      send_request(pfau_pkg::CMD_DIV, top, 63'd7);
      send_request(pfau_pkg::CMD_POW, 63'd3, 63'd2);
      send_request(pfau_pkg::CMD_POW, top, 63'd61);
      send_request(pfau_pkg::CMD_POW, 63'd5, top);
      send_request(pfau_pkg::CMD_POW, 63'd0, top);
      send_request(pfau_pkg::CMD_POW, 63'd0, top - 63'd9);
      send_request(pfau_pkg::CMD_NEG, 63'd0, 63'd0);
      send_request(pfau_pkg::CMD_NEG, 63'd1, 63'd0);
      send_request(pfau_pkg::CMD_ADD, '1, '1);
      send_request(pfau_pkg::CMD_NEG, '1, 63'd0);
      send_request(CMD_SPARE6, top, top);
      send_request(CMD_SPARE7, 63'd4, 63'd9);
      idle_sender(1);
   endtask

   task automatic test_small_moduli();
      write_prime(63'd2);
      send_random(10);
      write_prime(63'd15);
      send_request(pfau_pkg::CMD_DIV, 63'd7, 63'd5);
      send_request(pfau_pkg::CMD_POW, 63'd6, 63'd14);
      send_random(12);
      write_prime(63'd65521);
      send_random(20);
   endtask

   task automatic test_large_moduli();
      write_prime(63'h7fff_ffff_ffff_ffff);
      send_random(10);
      write_prime(63'd2305843009213693951);
      send_random(14);
   endtask

   // hold the receiver while requests keep coming so the input stalls
   task automatic test_backpressure();
      write_prime(63'd1000003);
      long_hold_req = 1;
      repeat (6) send_request(pfau_pkg::CMD_ADD, rand_operand(), rand_operand());
      idle_sender(1);
   endtask

   task automatic test_random();
      write_prime(63'd4294967291);
      send_random(30);
      write_prime(pfau_pkg::PrimeReset);
      send_random(20);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_prime();
      test_small_moduli();
      test_large_moduli();
      test_backpressure();
      test_random();
      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
